FILE: design/pid_position_loop_settle_detect_assert.svh
// Assertion macros used by the position loop core.
`ifndef PID_POSITION_LOOP_SETTLE_DETECT_ASSERT_SVH
`define PID_POSITION_LOOP_SETTLE_DETECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define PIDPLS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pidpls assertion failed");

// Next-cycle implication, disabled while reset is active.
`define PIDPLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pidpls assertion failed");

`endif

FILE: design/pidpls_pkg.sv
// Types and constants for the position loop with settle and stall detection.
`default_nettype none

package pidpls_pkg;

  localparam int PositionBits = 24;
  localparam int GainFracBits = 8;
  localparam int ErrBits      = PositionBits + 1;
  localparam int DerivBits    = PositionBits + 2;
  localparam int SumBits      = 32;
  localparam int CfgIdxBits   = 8;
  localparam int CfgDataBits  = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_GAIN_P             = 8'd0,
    REG_GAIN_I             = 8'd1,
    REG_GAIN_D             = 8'd2,
    REG_SETTLE_ERROR_LIMIT = 8'd3,
    REG_SETTLE_TICKS       = 8'd4,
    REG_STALL_RATE_LIMIT   = 8'd5,
    REG_STALL_TICKS        = 8'd6,
    REG_DRIVE_LIMIT        = 8'd7
  } cfg_reg_e;

  localparam logic [15:0] RstGainP      = 16'd256;
  localparam logic [15:0] RstGainI      = 16'd0;
  localparam logic [15:0] RstGainD      = 16'd0;
  localparam logic [23:0] RstSettleErr  = 24'd10;
  localparam logic [15:0] RstSettleTick = 16'd10;
  localparam logic [23:0] RstStallRate  = 24'd1;
  localparam logic [15:0] RstStallTick  = 16'd100;
  localparam logic [14:0] RstDriveLimit = 15'd12000;

  typedef struct packed {
    logic signed [PositionBits-1:0] measured_position;
    logic signed [PositionBits-1:0] target_position;
    logic                           restart;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               settled;
    logic               stalled;
  } out_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [23:0] settle_error_limit;
    logic [15:0] settle_ticks;
    logic [23:0] stall_rate_limit;
    logic [15:0] stall_ticks;
    logic [14:0] drive_limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/pidpls_cfg.sv
// Configuration register file for the position loop.
`default_nettype none

module pidpls_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pidpls_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  wire logic [pidpls_pkg::CfgDataBits-1:0]  cfg_data_i,
  output pidpls_pkg::cfg_t                         cfg_o
);

  pidpls_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p             <= pidpls_pkg::RstGainP;
      cfg_q.gain_i             <= pidpls_pkg::RstGainI;
      cfg_q.gain_d             <= pidpls_pkg::RstGainD;
      cfg_q.settle_error_limit <= pidpls_pkg::RstSettleErr;
      cfg_q.settle_ticks       <= pidpls_pkg::RstSettleTick;
      cfg_q.stall_rate_limit   <= pidpls_pkg::RstStallRate;
      cfg_q.stall_ticks        <= pidpls_pkg::RstStallTick;
      cfg_q.drive_limit        <= pidpls_pkg::RstDriveLimit;
    end else if (cfg_valid_i) begin
      // Drop writes to unmapped indexes.
      unique case (cfg_index_i)
        pidpls_pkg::REG_GAIN_P:             cfg_q.gain_p             <= cfg_data_i[15:0];
        pidpls_pkg::REG_GAIN_I:             cfg_q.gain_i             <= cfg_data_i[15:0];
        pidpls_pkg::REG_GAIN_D:             cfg_q.gain_d             <= cfg_data_i[15:0];
        pidpls_pkg::REG_SETTLE_ERROR_LIMIT: cfg_q.settle_error_limit <= cfg_data_i[23:0];
        pidpls_pkg::REG_SETTLE_TICKS:       cfg_q.settle_ticks       <= cfg_data_i[15:0];
        pidpls_pkg::REG_STALL_RATE_LIMIT:   cfg_q.stall_rate_limit   <= cfg_data_i[23:0];
        pidpls_pkg::REG_STALL_TICKS:        cfg_q.stall_ticks        <= cfg_data_i[15:0];
        pidpls_pkg::REG_DRIVE_LIMIT:        cfg_q.drive_limit        <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/pidpls_core.sv
// Control law, integral, settle and stall tracking: one tick per step.
`default_nettype none

`include "pid_position_loop_settle_detect_assert.svh"

module pidpls_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire pidpls_pkg::in_t   in_i,
  input  wire pidpls_pkg::cfg_t  cfg_i,
  output pidpls_pkg::out_t       res_o
);

  localparam int ErrBits   = pidpls_pkg::ErrBits;
  localparam int DerivBits = pidpls_pkg::DerivBits;
  localparam int SumBits   = pidpls_pkg::SumBits;
  localparam int FracBits  = pidpls_pkg::GainFracBits;
  localparam int TotBits   = 17 + SumBits + 2;
  localparam int MagBits   = DerivBits + 24;

  localparam logic signed [SumBits:0] SumMax = {2'b00, {(SumBits-1){1'b1}}};
  localparam logic signed [SumBits:0] SumMin = {2'b11, {(SumBits-1){1'b0}}};

  logic signed [ErrBits-1:0] last_error_q;
  logic signed [SumBits-1:0] error_sum_q;
  logic [15:0]               settle_count_q;
  logic [16:0]               stall_count_q;
  logic                      settled_q, stalled_q;

  logic signed [ErrBits-1:0] eff_last, err, last_error_d;
  logic signed [SumBits-1:0] eff_sum, error_sum_d;
  logic [15:0]               eff_settle, settle_count_d;
  logic [16:0]               eff_stall, stall_count_d;
  logic                      eff_settled, eff_stalled;
  logic signed [DerivBits-1:0] deriv;
  logic signed [SumBits:0]   acc;
  logic signed [SumBits-1:0] acc_sat;
  logic [1:0]                sgn_err, sgn_last;
  logic signed [16:0]        gp, gi, gd;
  logic signed [TotBits-1:0] total, lim;
  logic signed [15:0]        drive_calc, drive_lim;
  logic [ErrBits-1:0]        mag_err;
  logic [DerivBits-1:0]      mag_deriv;
  logic                      settle_hit, stall_hit, done_before;

  // Restart clears the tick's view of the state before anything else.
  always_comb begin
    eff_last    = in_i.restart ? '0 : last_error_q;
    eff_sum     = in_i.restart ? '0 : error_sum_q;
    eff_settle  = in_i.restart ? '0 : settle_count_q;
    eff_stall   = in_i.restart ? '0 : stall_count_q;
    eff_settled = in_i.restart ? 1'b0 : settled_q;
    eff_stalled = in_i.restart ? 1'b0 : stalled_q;
    done_before = eff_settled | eff_stalled;
  end

  always_comb begin
    err   = ErrBits'(in_i.target_position) - ErrBits'(in_i.measured_position);
    deriv = DerivBits'(err) - DerivBits'(eff_last);

    acc = (SumBits+1)'(eff_sum) + (SumBits+1)'(err);
    if (acc > SumMax)      acc_sat = SumMax[SumBits-1:0];
    else if (acc < SumMin) acc_sat = SumMin[SumBits-1:0];
    else                   acc_sat = acc[SumBits-1:0];

    // Sign code: negative flag and nonzero flag.
    sgn_err  = {err[ErrBits-1], err != '0};
    sgn_last = {eff_last[ErrBits-1], eff_last != '0};

    error_sum_d = (cfg_i.gain_i != '0) ? acc_sat : eff_sum;
    if (sgn_err != sgn_last) error_sum_d = '0;
  end

  always_comb begin
    gp    = $signed({1'b0, cfg_i.gain_p});
    gi    = $signed({1'b0, cfg_i.gain_i});
    gd    = $signed({1'b0, cfg_i.gain_d});
    total = TotBits'(gp) * TotBits'(err) + TotBits'(gi) * TotBits'(error_sum_d)
          + TotBits'(gd) * TotBits'(deriv);
    lim   = TotBits'({cfg_i.drive_limit, FracBits'(0)});
    drive_lim = $signed({1'b0, cfg_i.drive_limit});
    if (total >= lim)       drive_calc = drive_lim;
    else if (total <= -lim) drive_calc = -drive_lim;
    else                    drive_calc = total[FracBits +: 16];
  end

  always_comb begin
    mag_err   = err[ErrBits-1] ? ErrBits'(-err) : ErrBits'(err);
    mag_deriv = deriv[DerivBits-1] ? DerivBits'(-deriv) : DerivBits'(deriv);

    if (MagBits'(mag_err) < MagBits'(cfg_i.settle_error_limit)) begin
      settle_count_d = (eff_settle == 16'hFFFF) ? eff_settle : eff_settle + 16'd1;
    end else begin
      settle_count_d = '0;
    end
    settle_hit = settle_count_d >= cfg_i.settle_ticks;

    stall_count_d = eff_stall;
    if (!settle_hit && (MagBits'(mag_deriv) < MagBits'(cfg_i.stall_rate_limit))
        && (eff_stall != 17'h1FFFF)) begin
      stall_count_d = eff_stall + 17'd1;
    end
    stall_hit    = !settle_hit && (stall_count_d > 17'(cfg_i.stall_ticks));
    last_error_d = err;
  end

  always_comb begin
    if (done_before) begin
      res_o.drive   = '0;
      res_o.settled = eff_settled;
      res_o.stalled = eff_stalled;
    end else begin
      res_o.drive   = (settle_hit || stall_hit) ? 16'sd0 : drive_calc;
      res_o.settled = settle_hit;
      res_o.stalled = stall_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q   <= '0;
      error_sum_q    <= '0;
      settle_count_q <= '0;
      stall_count_q  <= '0;
      settled_q      <= 1'b0;
      stalled_q      <= 1'b0;
    end else if (step_i && !done_before) begin
      last_error_q   <= last_error_d;
      error_sum_q    <= error_sum_d;
      settle_count_q <= settle_count_d;
      stall_count_q  <= stall_count_d;
      settled_q      <= settle_hit;
      stalled_q      <= stall_hit;
    end
  end

  `PIDPLS_ASSERT_NOW(a_flags_exclusive, clk_i, rst_ni, 1'b1, !(settled_q && stalled_q))
  `PIDPLS_ASSERT_NOW(a_latched_drive_zero, clk_i, rst_ni,
                     step_i && !in_i.restart && (settled_q || stalled_q), res_o.drive == '0)
  `PIDPLS_ASSERT_NEXT(a_latched_holds_sum, clk_i, rst_ni,
                      step_i && !in_i.restart && (settled_q || stalled_q),
                      $stable(error_sum_q) && $stable(stall_count_q))
  `PIDPLS_ASSERT_NOW(a_drive_only_running, clk_i, rst_ni,
                     res_o.drive != '0, !res_o.settled && !res_o.stalled)

endmodule

`default_nettype wire

FILE: design/pid_position_loop_settle_detect.sv
// Top level: position PID loop with settle and stall detection.
//
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one control tick:
// measured and target position plus a restart bit that clears the loop state
// before that tick. Output channel (out_valid_o/out_ready_i, out_data_o)
// returns one beat per tick: the clamped drive and the settled/stalled flags.
// Configuration (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
// gains and limits; it is always ready, and writes to unmapped indexes drop.
// A tick goes through an input register, one combinational pass (three gain
// products, sum, clamp, counters) and a result register, which drives
// out_valid_o; one tick per cycle is sustained while the receiver takes every
// beat.
// The loop state updates in the same pass, so each tick sees the state left by
// the one before it.
// If the receiver stalls, the result register holds its beat and the input
// register takes one more tick; in_ready_o drops only when both are full.
// Reset empties both registers, restores register defaults and clears the
// integral, previous error, both counters and both flags.
`default_nettype none

module pid_position_loop_settle_detect (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire pidpls_pkg::in_t                    in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output pidpls_pkg::out_t                        out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pidpls_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [pidpls_pkg::CfgDataBits-1:0] cfg_data_i
);

  pidpls_pkg::cfg_t cfg;
  pidpls_pkg::in_t  in_q;
  pidpls_pkg::out_t res, out_q;
  logic             in_valid_q, out_valid_q;
  logic             advance;

  // Advance when a tick waits and the result slot is free or draining.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance) out_q <= res;
  end

  pidpls_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pidpls_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

endmodule

`default_nettype wire
